### design/assert_macros.svh
// Assertion macros shared by the RTL files of the contour straightness filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every clock edge outside reset.
`define CSF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("contour filter check failed");
// Checks that cond in one cycle is followed by nxt in the next cycle.
`define CSF_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("contour filter sequence check failed");
`else
`define CSF_ASSERT(label, clk, rst_n, prop)
`define CSF_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

### design/csf_pkg.sv
// Types and constants of the contour straightness filter.
`timescale 1ns / 1ps
`default_nettype none
package csf_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_LEN_W  = 6;
  localparam int RATIO_W    = 16;
  localparam int OUT_CNT_W  = 20;

  localparam logic [CFG_IDX_W-1:0] REG_MONO_WINDOW     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRAIGHT_WINDOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_RATIO      = 2'd2;

  localparam logic [CFG_LEN_W-1:0] MONO_WINDOW_RST     = 6'd8;
  localparam logic [CFG_LEN_W-1:0] STRAIGHT_WINDOW_RST = 6'd16;
  localparam logic [RATIO_W-1:0]   MONO_RATIO_RST      = 16'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WSTART,
    ST_WBOX,
    ST_WSCAN,
    ST_WEND,
    ST_UPDATE,
    ST_MUL,
    ST_RESULT
  } csf_state_t;

  // Which window length the shared scan is currently checking.
  typedef enum logic {
    WIN_MONO,
    WIN_STRAIGHT
  } csf_win_t;

endpackage
`default_nettype wire

### design/csf_ring.sv
// Point ring memory: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module csf_ring #(
  parameter int DEPTH = 33,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_x,
  input  logic [DW-1:0] wr_y,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_x,
  output logic [DW-1:0] rd_y
);

  logic [DW-1:0] mem_x [DEPTH];
  logic [DW-1:0] mem_y [DEPTH];
  logic [DW-1:0] rd_x_r;
  logic [DW-1:0] rd_y_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= mem_x[rd_addr];
    rd_y_r <= mem_y[rd_addr];
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule
`default_nettype wire

### design/contour_straightness_filter.sv
// Top level of the contour straightness filter: sequencer, shared box compare and end test.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in_     | input     | in_valid/in_stall  | pt_x, pt_y, last_point
//  out_    | output    | out_valid/out_stall| keep, is_monotone, has_straight,
//          |           |                    | pass_windows, contour_points
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A point is written to the ring when taken and closed by an update step; in between,
// each window that it decides is scanned over its clamped window length, and the update
// of a last point is followed by the end test. The window scan reads the ring through its
// single registered read port, one point per cycle, and one box compare unit serves both
// window lengths. Reset is synchronous and active low; the ring itself is not cleared.
// A finished result waits in the output register under out_stall while the next word
// is taken; only a later end test waits for that register to empty.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module contour_straightness_filter #(
  parameter int MAX_WINDOW = 32,
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [COORD_BITS-1:0]            in_pt_x,
  input  logic [COORD_BITS-1:0]            in_pt_y,
  input  logic                             in_last_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_keep,
  output logic                             out_is_monotone,
  output logic                             out_has_straight,
  output logic [csf_pkg::OUT_CNT_W-1:0]    out_pass_windows,
  output logic [csf_pkg::OUT_CNT_W-1:0]    out_contour_points,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [csf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import csf_pkg::*;

  localparam int RING_DEPTH = MAX_WINDOW + 1;
  localparam int AW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int AW1        = AW + 1;
  localparam int PW         = COUNT_BITS + RATIO_W;

  function automatic logic [AW-1:0] clamp_len(input logic [CFG_LEN_W-1:0] v);
    if (v == '0) begin
      clamp_len = AW'(1);
    end else if (32'(v) > 32'(MAX_WINDOW)) begin
      clamp_len = AW'(MAX_WINDOW);
    end else begin
      clamp_len = AW'(v);
    end
  endfunction

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    if (p == AW'(RING_DEPTH - 1)) begin
      ring_inc = '0;
    end else begin
      ring_inc = p + AW'(1);
    end
  endfunction

  // Ring slot that lies len places behind slot.
  function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] slot,
                                              input logic [AW-1:0] len);
    logic [AW1-1:0] s;
    s = {1'b0, slot} + AW1'(RING_DEPTH) - {1'b0, len};
    if (s >= AW1'(RING_DEPTH)) begin
      s = s - AW1'(RING_DEPTH);
    end
    ring_back = AW'(s);
  endfunction

  // Configuration registers.
  logic [CFG_LEN_W-1:0] mono_window_r, mono_window_nxt;
  logic [CFG_LEN_W-1:0] straight_window_r, straight_window_nxt;
  logic [RATIO_W-1:0]   ratio_r, ratio_nxt;

  // Control state.
  csf_state_t           state_r, state_nxt;
  csf_win_t             which_r, which_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [COUNT_BITS-1:0] points_r, points_nxt;
  logic [COUNT_BITS-1:0] passes_r, passes_nxt;
  logic                 straight_r, straight_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Per-point working registers.
  logic [COORD_BITS-1:0] x_r, x_nxt;
  logic [COORD_BITS-1:0] y_r, y_nxt;
  logic                  last_r, last_nxt;
  logic [AW-1:0]         lm_r, lm_nxt;
  logic [AW-1:0]         ls_r, ls_nxt;
  logic [COUNT_BITS-1:0] j_r, j_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         remain_r, remain_nxt;
  logic [COORD_BITS-1:0] lox_r, lox_nxt, hix_r, hix_nxt;
  logic [COORD_BITS-1:0] loy_r, loy_nxt, hiy_r, hiy_nxt;
  logic                  pass_r, pass_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;

  // Result register.
  logic                  keep_r, keep_nxt;
  logic                  mono_r, mono_nxt;
  logic                  has_str_r, has_str_nxt;
  logic [OUT_CNT_W-1:0]  pass_win_r, pass_win_nxt;
  logic [OUT_CNT_W-1:0]  pts_out_r, pts_out_nxt;

  // Ring interface.
  logic                  ring_we;
  logic [AW-1:0]         ring_raddr;
  logic [COORD_BITS-1:0] rd_x, rd_y;

  logic                  in_acc;
  logic [AW-1:0]         lm_cfg, ls_cfg;
  logic                  acc_mono_due, acc_str_due, str_due;
  logic [AW-1:0]         cur_len, win_start;
  logic                  pt_in_box;
  logic                  out_free;
  logic                  mono_test, str_test;

  csf_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW),
    .DW    (COORD_BITS)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (head_r),
    .wr_x    (in_pt_x),
    .wr_y    (in_pt_y),
    .rd_addr (ring_raddr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  assign in_acc       = in_valid && !in_stall;
  assign lm_cfg       = clamp_len(mono_window_r);
  assign ls_cfg       = clamp_len(straight_window_r);
  assign acc_mono_due = 32'(points_r) >= 32'(lm_cfg);
  assign acc_str_due  = 32'(points_r) >= 32'(ls_cfg);
  assign str_due      = 32'(j_r) >= 32'(ls_r);
  assign cur_len      = (which_r == WIN_STRAIGHT) ? ls_r : lm_r;
  assign win_start    = ring_back(head_r, cur_len);
  assign out_free     = !out_valid_r || !out_stall;

  // Shared compare unit: is the point just read inside the window's box?
  assign pt_in_box = (rd_x >= lox_r) && (rd_x <= hix_r) &&
                     (rd_y >= loy_r) && (rd_y <= hiy_r);

  assign mono_test = (32'(points_r) >= 32'(lm_r)) && ({passes_r, {RATIO_W{1'b0}}} > prod_r);
  assign str_test  = (32'(points_r) >= 32'(ls_r)) && straight_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (acc_mono_due || acc_str_due) begin
            state_nxt = ST_WSTART;
          end else begin
            state_nxt = ST_UPDATE;
          end
        end
      end
      ST_WSTART: state_nxt = ST_WBOX;
      ST_WBOX: begin
        state_nxt = (remain_r != '0) ? ST_WSCAN : ST_WEND;
      end
      ST_WSCAN: begin
        state_nxt = (remain_r != '0) ? ST_WSCAN : ST_WEND;
      end
      ST_WEND: begin
        if (which_r == WIN_MONO && str_due) begin
          state_nxt = ST_WSTART;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = last_r ? ST_MUL : ST_IDLE;
      ST_MUL:    state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    in_stall            = 1'b1;
    ring_we             = 1'b0;
    ring_raddr          = '0;
    mono_window_nxt     = mono_window_r;
    straight_window_nxt = straight_window_r;
    ratio_nxt           = ratio_r;
    which_nxt           = which_r;
    head_nxt            = head_r;
    points_nxt          = points_r;
    passes_nxt          = passes_r;
    straight_nxt        = straight_r;
    out_valid_nxt       = out_valid_r && out_stall;
    x_nxt               = x_r;
    y_nxt               = y_r;
    last_nxt            = last_r;
    lm_nxt              = lm_r;
    ls_nxt              = ls_r;
    j_nxt               = j_r;
    ptr_nxt             = ptr_r;
    remain_nxt          = remain_r;
    lox_nxt             = lox_r;
    hix_nxt             = hix_r;
    loy_nxt             = loy_r;
    hiy_nxt             = hiy_r;
    pass_nxt            = pass_r;
    prod_nxt            = prod_r;
    keep_nxt            = keep_r;
    mono_nxt            = mono_r;
    has_str_nxt         = has_str_r;
    pass_win_nxt        = pass_win_r;
    pts_out_nxt         = pts_out_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MONO_WINDOW:     mono_window_nxt     = cfg_data[CFG_LEN_W-1:0];
        REG_STRAIGHT_WINDOW: straight_window_nxt = cfg_data[CFG_LEN_W-1:0];
        REG_MONO_RATIO:      ratio_nxt           = cfg_data[RATIO_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_acc) begin
          ring_we   = 1'b1;
          x_nxt     = in_pt_x;
          y_nxt     = in_pt_y;
          last_nxt  = in_last_point;
          lm_nxt    = lm_cfg;
          ls_nxt    = ls_cfg;
          j_nxt     = points_r;
          which_nxt = acc_mono_due ? WIN_MONO : WIN_STRAIGHT;
        end
      end
      ST_WSTART: begin
        ring_raddr = win_start;
        ptr_nxt    = ring_inc(win_start);
        remain_nxt = cur_len - AW'(1);
      end
      ST_WBOX: begin
        // The start point and the newest point span the box.
        lox_nxt  = (rd_x < x_r) ? rd_x : x_r;
        hix_nxt  = (rd_x < x_r) ? x_r : rd_x;
        loy_nxt  = (rd_y < y_r) ? rd_y : y_r;
        hiy_nxt  = (rd_y < y_r) ? y_r : rd_y;
        pass_nxt = 1'b1;
        if (remain_r != '0) begin
          ring_raddr = ptr_r;
          ptr_nxt    = ring_inc(ptr_r);
          remain_nxt = remain_r - AW'(1);
        end
      end
      ST_WSCAN: begin
        pass_nxt = pass_r && pt_in_box;
        if (remain_r != '0) begin
          ring_raddr = ptr_r;
          ptr_nxt    = ring_inc(ptr_r);
          remain_nxt = remain_r - AW'(1);
        end
      end
      ST_WEND: begin
        if (which_r == WIN_MONO) begin
          if (pass_r && passes_r != '1) begin
            passes_nxt = passes_r + COUNT_BITS'(1);
          end
          which_nxt = WIN_STRAIGHT;
        end else if (pass_r) begin
          straight_nxt = 1'b1;
        end
      end
      ST_UPDATE: begin
        head_nxt = ring_inc(head_r);
        if (points_r != '1) begin
          points_nxt = points_r + COUNT_BITS'(1);
        end
      end
      ST_MUL: begin
        prod_nxt = PW'(points_r) * PW'(ratio_r);
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          keep_nxt      = mono_test || str_test;
          mono_nxt      = mono_test;
          has_str_nxt   = str_test;
          pass_win_nxt  = OUT_CNT_W'(passes_r);
          pts_out_nxt   = OUT_CNT_W'(points_r);
          head_nxt      = '0;
          points_nxt    = '0;
          passes_nxt    = '0;
          straight_nxt  = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      which_r           <= WIN_MONO;
      head_r            <= '0;
      points_r          <= '0;
      passes_r          <= '0;
      straight_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      mono_window_r     <= MONO_WINDOW_RST;
      straight_window_r <= STRAIGHT_WINDOW_RST;
      ratio_r           <= MONO_RATIO_RST;
    end else begin
      state_r           <= state_nxt;
      which_r           <= which_nxt;
      head_r            <= head_nxt;
      points_r          <= points_nxt;
      passes_r          <= passes_nxt;
      straight_r        <= straight_nxt;
      out_valid_r       <= out_valid_nxt;
      mono_window_r     <= mono_window_nxt;
      straight_window_r <= straight_window_nxt;
      ratio_r           <= ratio_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    last_r     <= last_nxt;
    lm_r       <= lm_nxt;
    ls_r       <= ls_nxt;
    j_r        <= j_nxt;
    ptr_r      <= ptr_nxt;
    remain_r   <= remain_nxt;
    lox_r      <= lox_nxt;
    hix_r      <= hix_nxt;
    loy_r      <= loy_nxt;
    hiy_r      <= hiy_nxt;
    pass_r     <= pass_nxt;
    prod_r     <= prod_nxt;
    keep_r     <= keep_nxt;
    mono_r     <= mono_nxt;
    has_str_r  <= has_str_nxt;
    pass_win_r <= pass_win_nxt;
    pts_out_r  <= pts_out_nxt;
  end

  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_keep           = keep_r;
  assign out_is_monotone    = mono_r;
  assign out_has_straight   = has_str_r;
  assign out_pass_windows   = pass_win_r;
  assign out_contour_points = pts_out_r;

  // Each point adds at most one passing window, and only after the first window length.
  `CSF_ASSERT(a_passes_le_points, clk, rst_n, passes_r <= points_r)
  // The end test only runs for a word that carried the last mark.
  `CSF_ASSERT(a_result_needs_last, clk, rst_n, (state_r != ST_MUL) || last_r)
  // The window scan never addresses past the end of the ring.
  `CSF_ASSERT(a_raddr_in_ring, clk, rst_n, 32'(ring_raddr) < 32'(RING_DEPTH))
  // A result that is loaded is shown in the next cycle.
  `CSF_ASSERT_NEXT(a_result_shown, clk, rst_n, (state_r == ST_RESULT) && out_free, out_valid)

endmodule
`default_nettype wire

### test/contour_straightness_filter_tb.sv
// Self-checking testbench for the contour straightness filter with its own contour predictor.
`timescale 1ns / 1ps
module contour_straightness_filter_tb;
  import csf_pkg::*;

  localparam int MAX_WIN = 32;
  localparam int RING_LEN = MAX_WIN + 1;
  localparam int COORD_W = 16;
  localparam int COUNT_W = 20;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam int MAX_WAIT = 11;
  localparam int SETTLE_CYCLES = 2 * MAX_WIN + 40;
  localparam int IDLE_LIMIT = 4000;
  localparam int RANDOM_POINTS = 550;
  localparam int MIN_CONTOURS = 40;

  typedef enum int {SHAPE_RAMP, SHAPE_NOISY, SHAPE_FLAT, SHAPE_SCATTER} shape_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last;
    bit                 drain;
  } point_t;

  typedef struct {
    logic               keep;
    logic               mono;
    logic               straight;
    logic [COUNT_W-1:0] passes;
    logic [COUNT_W-1:0] count;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [COORD_W-1:0] in_pt_x = '0;
  logic [COORD_W-1:0] in_pt_y = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_keep;
  logic out_is_monotone;
  logic out_has_straight;
  logic [OUT_CNT_W-1:0] out_pass_windows;
  logic [OUT_CNT_W-1:0] out_contour_points;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MONO_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  contour_straightness_filter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pt_x            (in_pt_x),
    .in_pt_y            (in_pt_y),
    .in_last_point      (in_last_point),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_keep           (out_keep),
    .out_is_monotone    (out_is_monotone),
    .out_has_straight   (out_has_straight),
    .out_pass_windows   (out_pass_windows),
    .out_contour_points (out_contour_points),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: recent points of the open contour and its running tallies.
  logic [COORD_W-1:0] ring_xs [RING_LEN] = '{default: '0};
  logic [COORD_W-1:0] ring_ys [RING_LEN] = '{default: '0};
  int unsigned        head_pos = 0;
  logic [COUNT_W-1:0] pts_seen = '0;
  logic [COUNT_W-1:0] mono_hits = '0;
  bit                 straight_hit = 1'b0;
  logic [CFG_LEN_W-1:0] mono_len_reg = MONO_WINDOW_RST;
  logic [CFG_LEN_W-1:0] straight_len_reg = STRAIGHT_WINDOW_RST;
  logic [RATIO_W-1:0]   ratio_reg = MONO_RATIO_RST;

  point_t   pending_points[$];
  verdict_t verdicts_due[$];

  int pushed_points = 0;
  int accepted_points = 0;
  int ended_contours = 0;
  int settings_used = 1;
  int results_checked = 0;
  int mismatches = 0;
  int send_quiet = 0;
  int recv_quiet = 0;
  int gap_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  function automatic int unsigned clamp_window(logic [CFG_LEN_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIN) return MAX_WIN;
    return 32'(v);
  endfunction

  // True when every point of the window lies inside the box of its two endpoints.
  function automatic bit box_holds(int unsigned len, int unsigned newest);
    int unsigned first;
    int unsigned idx;
    logic [COORD_W-1:0] lox, hix, loy, hiy;
    bit ok;
    first = (newest + RING_LEN - len) % RING_LEN;
    lox = (ring_xs[first] < ring_xs[newest]) ? ring_xs[first] : ring_xs[newest];
    hix = (ring_xs[first] < ring_xs[newest]) ? ring_xs[newest] : ring_xs[first];
    loy = (ring_ys[first] < ring_ys[newest]) ? ring_ys[first] : ring_ys[newest];
    hiy = (ring_ys[first] < ring_ys[newest]) ? ring_ys[newest] : ring_ys[first];
    ok = 1'b1;
    for (int k = 0; k < len; k++) begin
      idx = (first + k) % RING_LEN;
      if (ring_xs[idx] < lox || ring_xs[idx] > hix || ring_ys[idx] < loy || ring_ys[idx] > hiy)
        ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic predict_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
    int unsigned lm, ls, slot;
    longint unsigned n, lhs, rhs;
    verdict_t v;
    lm = clamp_window(mono_len_reg);
    ls = clamp_window(straight_len_reg);
    slot = head_pos;
    ring_xs[slot] = x;
    ring_ys[slot] = y;
    if (pts_seen >= lm && box_holds(lm, slot) && mono_hits != COUNT_TOP) mono_hits++;
    if (pts_seen >= ls && box_holds(ls, slot)) straight_hit = 1'b1;
    head_pos = (slot + 1) % RING_LEN;
    if (pts_seen != COUNT_TOP) pts_seen++;
    if (last) begin
      n = pts_seen;
      lhs = mono_hits;
      lhs = lhs << 16;
      rhs = n * ratio_reg;
      v.mono = (n >= lm) && (lhs > rhs);
      v.straight = (n >= ls) && straight_hit;
      v.keep = v.mono || v.straight;
      v.passes = mono_hits;
      v.count = pts_seen;
      verdicts_due.push_back(v);
      head_pos = 0;
      pts_seen = '0;
      mono_hits = '0;
      straight_hit = 1'b0;
    end
  endtask

  function automatic int draw_wait(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic report_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // A word that is flagged to drain waits until no result is outstanding.
  always @(posedge clk) begin : drive_points
    point_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0 &&
                   !(pending_points[0].drain && (in_valid || verdicts_due.size() > 0))) begin
        nxt = pending_points.pop_front();
        in_pt_x <= nxt.x;
        in_pt_y <= nxt.y;
        in_last_point <= nxt.last;
        in_valid <= 1'b1;
        gap_left = draw_wait(send_quiet);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) hold_left = draw_wait(recv_quiet);
      else if (hold_left > 0) hold_left--;
      out_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin : watch_results
    verdict_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_point(in_pt_x, in_pt_y, in_last_point);
        accepted_points++;
      end
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got keep=%0b mono=%0b straight=%0b",
                   $time, out_keep, out_is_monotone, out_has_straight);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          report_field("keep", want.keep, out_keep);
          report_field("is_monotone", want.mono, out_is_monotone);
          report_field("has_straight", want.straight, out_has_straight);
          report_field("pass_windows", want.passes, out_pass_windows);
          report_field("contour_points", want.count, out_contour_points);
          results_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("contour_straightness_filter test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [COORD_W-1:0] step_coord(logic [COORD_W-1:0] c, int delta);
    int v;
    v = int'(c) + delta;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[COORD_W-1:0];
  endfunction

  task automatic queue_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last, bit drain);
    point_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    p.drain = drain;
    pending_points.push_back(p);
    pushed_points++;
    if (last) ended_contours++;
  endtask

  task automatic queue_contour(int len, shape_t shape, bit closed, bit drain);
    logic [COORD_W-1:0] x, y;
    int sx, sy, reach, dx, dy;
    x = COORD_W'($urandom);
    y = COORD_W'($urandom);
    if ($urandom_range(0, 7) == 0) x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(0, 7) == 0) y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    sx = $urandom_range(0, 1) ? 1 : -1;
    sy = $urandom_range(0, 1) ? 1 : -1;
    reach = 1 << $urandom_range(0, 10);
    for (int k = 0; k < len; k++) begin
      dx = sx * int'($urandom_range(0, reach));
      dy = sy * int'($urandom_range(0, reach));
      case (shape)
        SHAPE_RAMP: begin
          x = step_coord(x, dx);
          y = step_coord(y, dy);
        end
        SHAPE_NOISY: begin
          // Occasional backtracks break some windows but not all of them.
          if ($urandom_range(0, 3) == 0) dx = -dx;
          if ($urandom_range(0, 3) == 0) dy = -dy;
          x = step_coord(x, dx);
          y = step_coord(y, dy);
        end
        SHAPE_FLAT: ;
        SHAPE_SCATTER: begin
          x = COORD_W'($urandom);
          y = COORD_W'($urandom);
        end
      endcase
      queue_point(x, y, closed && (k == len - 1), drain && (k == 0));
    end
  endtask

  task automatic queue_random_phase(int points);
    int start, len, pick;
    shape_t shape;
    start = pushed_points;
    while (pushed_points - start < points) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45) : $urandom_range(1, 18);
      pick = $urandom_range(0, 9);
      if (pick < 5) shape = SHAPE_RAMP;
      else if (pick < 7) shape = SHAPE_NOISY;
      else if (pick < 8) shape = SHAPE_FLAT;
      else shape = SHAPE_SCATTER;
      queue_contour(len, shape, 1'b1, $urandom_range(0, 14) == 0);
    end
    // Half the phases leave a contour open, so the next setting applies in mid-contour.
    if ($urandom_range(0, 1)) queue_contour($urandom_range(1, 12), SHAPE_RAMP, 1'b0, 1'b0);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (accepted_points != pushed_points || verdicts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_filter(logic [CFG_DATA_W-1:0] mono_w, logic [CFG_DATA_W-1:0] straight_w,
                                logic [CFG_DATA_W-1:0] ratio);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{REG_MONO_WINDOW, REG_STRAIGHT_WINDOW, REG_MONO_RATIO};
    val = '{mono_w, straight_w, ratio};
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_MONO_WINDOW:     mono_len_reg = val[i][CFG_LEN_W-1:0];
        REG_STRAIGHT_WINDOW: straight_len_reg = val[i][CFG_LEN_W-1:0];
        REG_MONO_RATIO:      ratio_reg = val[i][RATIO_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int directed_points;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed contours under the reset settings.
    queue_point(16'h0000, 16'h0000, 1'b1, 1'b0);
    queue_contour(8, SHAPE_RAMP, 1'b1, 1'b0);
    for (int k = 0; k < 10; k++) queue_point(16'hFFFF, 16'hFFFF, k == 9, k == 0);
    for (int k = 0; k < 6; k++)
      queue_point(k % 2 ? 16'hFFFF : 16'h0000, k % 2 ? 16'h0000 : 16'hFFFF, k == 5, 1'b0);
    directed_points = pushed_points;
    wait_idle();

    // Extremes first, including lengths of zero and above the maximum.
    program_filter(16'd1, 16'd1, 16'h0000);
    queue_random_phase(70);
    wait_idle();
    program_filter(16'd32, 16'd32, 16'hFFFF);
    queue_random_phase(70);
    wait_idle();
    program_filter(16'hFFC0, 16'h003F, 16'h0001);
    queue_random_phase(70);
    wait_idle();
    program_filter(16'd33, 16'd2, 16'h8000);
    queue_random_phase(70);
    wait_idle();
    while (pushed_points - directed_points < RANDOM_POINTS || ended_contours < MIN_CONTOURS) begin
      program_filter(CFG_DATA_W'($urandom_range(0, 63) | ($urandom & 16'hFFC0)),
                     CFG_DATA_W'($urandom_range(0, 63) | ($urandom & 16'hFFC0)),
                     CFG_DATA_W'($urandom));
      queue_random_phase(70);
      wait_idle();
    end

    $display("Sent %0d points in %0d closed contours under %0d register settings.",
             pushed_points, ended_contours, settings_used);
    $display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("contour_straightness_filter test passed");
    else
      $display("contour_straightness_filter test failed");
    $finish;
  end

endmodule
